### design/mrb_pkg.sv
// shared constants, command types and back-end state encoding for the ring buffer
package mrb_pkg;

    // defaults for the top-level parameters
    localparam int STORE_DEPTH_DEF    = 16384;
    localparam int READER_COUNT_DEF   = 2;
    localparam int MAX_READ_BURST_DEF = 64;

    // command queue between front and back end (power of two)
    localparam int CMD_QUEUE_DEPTH = 4;

    // fixed field widths
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 7;
    localparam int TOTAL_W = 32;

    // operation codes on the request channel
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // classified command kinds
    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_READ,
        CMD_NULL
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [BYTE_W-1:0]  data;
        logic               reader;
        logic [LEN_W-1:0]   len;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CHECK,
        BK_SIZE,
        BK_BURST,
        BK_NULL
    } back_state_t;

endpackage

### design/mrb_req_if.sv
// request channel: write bytes and read requests
interface mrb_req_if;
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [mrb_pkg::BYTE_W-1:0]    write_byte;
    logic                          reader_select;
    logic [mrb_pkg::LEN_W-1:0]     read_length;

    modport source (
        output valid, operation, write_byte, reader_select, read_length,
        input  ready
    );
    modport sink (
        input  valid, operation, write_byte, reader_select, read_length,
        output ready
    );
endinterface

### design/mrb_rsp_if.sv
// response channel: delivered bytes with status flags
interface mrb_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [mrb_pkg::BYTE_W-1:0]    read_byte;
    logic                          byte_valid;
    logic                          last_of_read;
    logic                          reader_lapped;

    modport source (
        output valid, read_byte, byte_valid, last_of_read, reader_lapped,
        input  ready
    );
    modport sink (
        input  valid, read_byte, byte_valid, last_of_read, reader_lapped,
        output ready
    );
endinterface

### design/mrb_front.sv
// front end: takes request transactions and classifies them into commands
module mrb_front #(
    parameter int READER_COUNT   = mrb_pkg::READER_COUNT_DEF,
    parameter int MAX_READ_BURST = mrb_pkg::MAX_READ_BURST_DEF
) (
    mrb_req_if.sink        req,
    input  logic           queue_ready,
    output logic           push,
    output mrb_pkg::cmd_t  cmd
);
    import mrb_pkg::*;

    logic [LEN_W-1:0] len_sat;
    logic             reader_ok;

    assign req.ready = queue_ready;
    assign push      = req.valid && queue_ready;

    always_comb
    begin
        len_sat   = (32'(req.read_length) > 32'(MAX_READ_BURST)) ?
                    LEN_W'(MAX_READ_BURST) : req.read_length;
        reader_ok = int'(req.reader_select) < READER_COUNT;

        cmd.data   = req.write_byte;
        cmd.reader = req.reader_select;
        cmd.len    = len_sat;
        unique case (req.operation)
            OP_WRITE: cmd.kind = CMD_WRITE;
            OP_READ:
            begin
                // unknown reader or zero length gets the empty answer
                if (!reader_ok || len_sat == '0)
                    cmd.kind = CMD_NULL;
                else
                    cmd.kind = CMD_READ;
            end
            default: cmd.kind = CMD_NULL;
        endcase
    end

endmodule

### design/mrb_cmd_queue.sv
// small command fifo between front and back end
module mrb_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mrb_pkg::cmd_t  push_cmd,
    output logic           push_ready,
    input  logic           pop,
    output mrb_pkg::cmd_t  pop_cmd,
    output logic           pop_valid
);
    import mrb_pkg::*;

    localparam int PTR_W = $clog2(CMD_QUEUE_DEPTH);

    cmd_t             slot_reg [CMD_QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   fill_reg, fill_next;
    logic             do_push, do_pop;

    assign push_ready = fill_reg != (PTR_W+1)'(CMD_QUEUE_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_cmd    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        do_push     = push && push_ready;
        do_pop      = pop && pop_valid;
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + 1'b1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

### design/mrb_back.sv
// back end: byte store, write head, reader state and burst sequencer
module mrb_back #(
    parameter int STORE_DEPTH    = mrb_pkg::STORE_DEPTH_DEF,
    parameter int READER_COUNT   = mrb_pkg::READER_COUNT_DEF,
    parameter int MAX_READ_BURST = mrb_pkg::MAX_READ_BURST_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  mrb_pkg::cmd_t  cmd,
    output logic           cmd_pop,
    mrb_rsp_if.source      rsp
);
    import mrb_pkg::*;

    localparam int POS_W = $clog2(STORE_DEPTH);
    localparam int CNT_W = $clog2(MAX_READ_BURST + 1);

    function automatic logic [POS_W-1:0] pos_step(input logic [POS_W-1:0] p);
        return (p == POS_W'(STORE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    logic [BYTE_W-1:0]  store_mem [STORE_DEPTH];

    back_state_t        state_reg, state_next;
    logic [POS_W-1:0]   wr_pos_reg, wr_pos_next;
    logic [TOTAL_W-1:0] written_reg, written_next;
    logic [POS_W-1:0]   rd_pos_reg [READER_COUNT];
    logic [POS_W-1:0]   rd_pos_next [READER_COUNT];
    logic [TOTAL_W-1:0] rd_total_reg [READER_COUNT];
    logic [TOTAL_W-1:0] rd_total_next [READER_COUNT];
    logic [CNT_W-1:0]   left_reg, left_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic               sel_reg, sel_next;
    logic [CNT_W-1:0]   len_reg, len_next;
    logic [TOTAL_W-1:0] diff_reg, diff_next;
    logic               lapped_reg, lapped_next;
    logic               byte_valid_reg, byte_valid_next;
    logic               last_reg, last_next;
    logic               rsp_lapped_reg, rsp_lapped_next;
    logic [BYTE_W-1:0]  rd_data_reg;

    logic               mem_we;
    logic               issue;
    logic               out_free;
    logic [POS_W-1:0]   cur_pos;
    logic [TOTAL_W-1:0] cur_total;
    logic [TOTAL_W-1:0] avail;

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.read_byte     = byte_valid_reg ? rd_data_reg : '0;
    assign rsp.byte_valid    = byte_valid_reg;
    assign rsp.last_of_read  = last_reg;
    assign rsp.reader_lapped = rsp_lapped_reg;

    always_comb
    begin
        state_next      = state_reg;
        wr_pos_next     = wr_pos_reg;
        written_next    = written_reg;
        rd_pos_next     = rd_pos_reg;
        rd_total_next   = rd_total_reg;
        left_next       = left_reg;
        sel_next        = sel_reg;
        len_next        = len_reg;
        diff_next       = diff_reg;
        lapped_next     = lapped_reg;
        byte_valid_next = byte_valid_reg;
        last_next       = last_reg;
        rsp_lapped_next = rsp_lapped_reg;
        cmd_pop         = 1'b0;
        mem_we          = 1'b0;
        issue           = 1'b0;
        avail           = '0;
        out_free        = !rsp_valid_reg || rsp.ready;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;

        cur_pos   = '0;
        cur_total = '0;
        for (int i = 0; i < READER_COUNT; i++)
        begin
            if (i == int'(sel_reg))
            begin
                cur_pos   = rd_pos_reg[i];
                cur_total = rd_total_reg[i];
            end
        end

        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.kind)
                        CMD_WRITE:
                        begin
                            mem_we       = 1'b1;
                            wr_pos_next  = pos_step(wr_pos_reg);
                            written_next = written_reg + 1'b1;
                        end
                        CMD_READ:
                        begin
                            sel_next   = cmd.reader;
                            len_next   = CNT_W'(cmd.len);
                            state_next = BK_CHECK;
                        end
                        default: state_next = BK_NULL;
                    endcase
                end
            end
            BK_CHECK:
            begin
                diff_next  = written_reg - cur_total;
                state_next = BK_SIZE;
            end
            BK_SIZE:
            begin
                // overrun reader restarts at the oldest byte, one full store behind
                lapped_next = diff_reg > TOTAL_W'(STORE_DEPTH);
                avail       = lapped_next ? TOTAL_W'(STORE_DEPTH) : diff_reg;
                left_next   = (avail < TOTAL_W'(len_reg)) ? CNT_W'(avail) : len_reg;
                if (lapped_next)
                begin
                    for (int i = 0; i < READER_COUNT; i++)
                    begin
                        if (i == int'(sel_reg))
                        begin
                            rd_pos_next[i]   = wr_pos_reg;
                            rd_total_next[i] = written_reg - TOTAL_W'(STORE_DEPTH);
                        end
                    end
                end
                state_next = (avail == '0) ? BK_NULL : BK_BURST;
            end
            BK_BURST:
            begin
                if (out_free)
                begin
                    issue           = 1'b1;
                    rsp_valid_next  = 1'b1;
                    byte_valid_next = 1'b1;
                    last_next       = left_reg == CNT_W'(1);
                    rsp_lapped_next = lapped_reg;
                    left_next       = left_reg - 1'b1;
                    for (int i = 0; i < READER_COUNT; i++)
                    begin
                        if (i == int'(sel_reg))
                        begin
                            rd_pos_next[i]   = pos_step(cur_pos);
                            rd_total_next[i] = cur_total + 1'b1;
                        end
                    end
                    if (left_reg == CNT_W'(1))
                        state_next = BK_IDLE;
                end
            end
            BK_NULL:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    byte_valid_next = 1'b0;
                    last_next       = 1'b1;
                    rsp_lapped_next = 1'b0;
                    state_next      = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            wr_pos_reg    <= '0;
            written_reg   <= '0;
            left_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < READER_COUNT; i++)
            begin
                rd_pos_reg[i]   <= '0;
                rd_total_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            wr_pos_reg    <= wr_pos_next;
            written_reg   <= written_next;
            left_reg      <= left_next;
            rsp_valid_reg <= rsp_valid_next;
            rd_pos_reg    <= rd_pos_next;
            rd_total_reg  <= rd_total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg        <= sel_next;
        len_reg        <= len_next;
        diff_reg       <= diff_next;
        lapped_reg     <= lapped_next;
        byte_valid_reg <= byte_valid_next;
        last_reg       <= last_next;
        rsp_lapped_reg <= rsp_lapped_next;
    end

    // byte store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[wr_pos_reg] <= cmd.data;
    end

    always_ff @(posedge clk)
    begin
        if (issue)
            rd_data_reg <= store_mem[cur_pos];
    end

endmodule

### design/multi_reader_overwrite_ring_buffer.sv
// top level of the overwriting byte ring buffer with independent readers
//
// A single writer appends one byte per write transaction into a store of
// STORE_DEPTH bytes, wrapping and overwriting the oldest data, while up to
// READER_COUNT readers each keep their own position and 32-bit consumed count.
// A read transaction names a reader and asks for up to MAX_READ_BURST bytes
// (longer requests are clipped); the answer is one response transaction per
// byte, oldest first, the last one marked, or a single response with
// byte_valid low when nothing is unread, the length is zero or the reader does
// not exist. When the writer has run more than one full store ahead of a
// reader, the reader restarts at the oldest byte and every response of that
// request carries reader_lapped. Timing: the request side takes a transaction
// every cycle while the 4-entry command queue has room. The back end works
// through commands one at a time: a write is stored as it is dequeued, a read
// is dequeued, checked for a lap and sized before its bytes are delivered; a
// zero-length or unknown-reader request is answered straight after dequeue,
// and a reader with nothing unread after the sizing step; bytes stream out
// at one per cycle as fast as the single read port of the byte store allows,
// held only by rsp.ready. The store is not cleared at reset; bytes that were
// never written read as undefined.
module multi_reader_overwrite_ring_buffer #(
    parameter int STORE_DEPTH    = mrb_pkg::STORE_DEPTH_DEF,
    parameter int READER_COUNT   = mrb_pkg::READER_COUNT_DEF,
    parameter int MAX_READ_BURST = mrb_pkg::MAX_READ_BURST_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    mrb_req_if.sink    req,
    mrb_rsp_if.source  rsp
);
    import mrb_pkg::*;

    // classified commands from the front end
    cmd_t front_cmd;
    logic front_push;
    logic queue_ready;

    // commands waiting for the back end
    cmd_t back_cmd;
    logic back_valid;
    logic back_pop;

    // front end: decode operation, clip length, flag requests that get the empty answer
    mrb_front #(
        .READER_COUNT   (READER_COUNT),
        .MAX_READ_BURST (MAX_READ_BURST)
    ) u_front (
        .req         (req),
        .queue_ready (queue_ready),
        .push        (front_push),
        .cmd         (front_cmd)
    );

    // decoupling queue so requests keep flowing during a burst
    mrb_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_push),
        .push_cmd   (front_cmd),
        .push_ready (queue_ready),
        .pop        (back_pop),
        .pop_cmd    (back_cmd),
        .pop_valid  (back_valid)
    );

    // back end: store, lap check and byte streaming
    mrb_back #(
        .STORE_DEPTH    (STORE_DEPTH),
        .READER_COUNT   (READER_COUNT),
        .MAX_READ_BURST (MAX_READ_BURST)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (back_valid),
        .cmd       (back_cmd),
        .cmd_pop   (back_pop),
        .rsp       (rsp)
    );

endmodule

### design/mrb_checker.sv
// port-level checks on the response channel, bound to the top level
module mrb_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [mrb_pkg::BYTE_W-1:0]  read_byte,
    input logic                        byte_valid,
    input logic                        last_of_read,
    input logic                        reader_lapped
);

    // a stalled response stays up
    property p_hold_valid;
        @(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid;
    endproperty
    a_hold_valid: assert property (p_hold_valid)
        else $error("response dropped while stalled");

    // a stalled response keeps its payload
    property p_hold_payload;
        @(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(read_byte) && $stable(byte_valid) &&
            $stable(last_of_read) && $stable(reader_lapped);
    endproperty
    a_hold_payload: assert property (p_hold_payload)
        else $error("response payload changed while stalled");

    // an empty answer is a single, final, clean transaction
    property p_empty_answer;
        @(posedge clk) disable iff (!rst_n)
        rsp_valid && !byte_valid |-> last_of_read && !reader_lapped && read_byte == '0;
    endproperty
    a_empty_answer: assert property (p_empty_answer)
        else $error("empty answer with wrong flags");

    // within a burst every accepted non-final response carries a byte
    property p_burst_body;
        @(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready && !last_of_read |-> byte_valid;
    endproperty
    a_burst_body: assert property (p_burst_body)
        else $error("non-final response without data");

endmodule

bind multi_reader_overwrite_ring_buffer mrb_checker u_mrb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .read_byte     (rsp.read_byte),
    .byte_valid    (rsp.byte_valid),
    .last_of_read  (rsp.last_of_read),
    .reader_lapped (rsp.reader_lapped)
);
